>>> hdl/srpd_pkg.sv
// ----------------------------------------------------------------------------
// srpd_pkg
// Shared constants and types for the run-length sprite pixel decoder.
// ----------------------------------------------------------------------------
package srpd_pkg;

	// sprite size in pixels
	localparam int unsigned PIXEL_COUNT = 1024;

	// width of a pixel position, able to hold PIXEL_COUNT itself
	localparam int unsigned POS_W = $clog2(PIXEL_COUNT + 1);
	// width used when comparing a 16-bit count against the room left
	localparam int unsigned CMP_W = (POS_W > 16) ? POS_W : 16;

	// fixed field widths of a result beat
	localparam int unsigned IDX_OUT_W  = 11;
	localparam int unsigned LEN_OUT_W  = 11;
	localparam int unsigned ARGB_W     = 32;

	localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;
	localparam logic [7:0] BYTE_ZERO    = 8'h00;

	// result queue
	localparam int unsigned QUEUE_DEPTH = 4;
	localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic [4:0] {
		PH_TRANS_LO = 5'b00001,
		PH_TRANS_HI = 5'b00010,
		PH_COLOR_LO = 5'b00100,
		PH_COLOR_HI = 5'b01000,
		PH_PIXEL    = 5'b10000
	} phase_t;

	typedef struct packed {
		logic [IDX_OUT_W-1:0] start_index;
		logic [LEN_OUT_W-1:0] run_length;
		logic [ARGB_W-1:0]    argb_value;
		logic                 sprite_done;
	} res_t;

endpackage

>>> hdl/sprite_rle_pixel_decoder.sv
// ----------------------------------------------------------------------------
// sprite_rle_pixel_decoder
// Parses a run-length compressed sprite byte by byte into ARGB pixel runs.
// ----------------------------------------------------------------------------
//
//  channel   handshake              payload
//  -------   --------------------   ---------------------------------------------
//  in        in_valid / in_stall    data_byte, last_byte
//  out       out_valid / out_stall  start_index, run_length, argb_value, sprite_done
//  cfg       cfg_we                 cfg_wdata (alpha_mode)
//
// One input beat per cycle while in_stall is low. Each byte updates the parse
// registers in the cycle it is accepted and pushes zero, one or two results
// into a four-entry result queue; they reach the output behind older results.
// in_stall rises while the queue holds three or more results, so a byte that
// ends a sprite (a run plus the padding run) always finds room.
// arst_n clears the parse state, the queue count and alpha_mode.
// ----------------------------------------------------------------------------
module sprite_rle_pixel_decoder (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_wdata,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  data_byte,
	input  logic        last_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [10:0] start_index,
	output logic [10:0] run_length,
	output logic [31:0] argb_value,
	output logic        sprite_done
);

	localparam int unsigned POS_W = srpd_pkg::POS_W;
	localparam int unsigned CMP_W = srpd_pkg::CMP_W;
	localparam int unsigned QD    = srpd_pkg::QUEUE_DEPTH;
	localparam int unsigned QC_W  = srpd_pkg::QCNT_W;
	localparam logic [POS_W-1:0] TOTAL = POS_W'(srpd_pkg::PIXEL_COUNT);

	logic                alpha_mode_q;
	srpd_pkg::phase_t    phase_q, phase_d;
	logic [7:0]          low_q, low_d;
	logic [15:0]         left_q, left_d;
	logic [1:0]          pbi_q, pbi_d;
	logic [23:0]         color_q, color_d;
	logic [POS_W-1:0]    wp_q, wp_d;

	srpd_pkg::res_t      slot_q [QD];
	logic [QC_W-1:0]     occ_q;

	logic                in_acc, out_acc;
	logic                run_vld, pad_vld;
	srpd_pkg::res_t      run_res, pad_res, first_res;
	logic [QC_W-1:0]     base, n_push;

	// parse step working values
	logic [15:0]         cnt;
	logic [POS_W-1:0]    room, len, wp_mid;
	logic [23:0]         lat;
	logic [7:0]          alpha;
	logic                done_px;
	logic [15:0]         left_dec;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alpha_mode_q <= 1'b0;
		end else if (cfg_we) begin
			alpha_mode_q <= cfg_wdata;
		end
	end

	assign in_stall = occ_q > QC_W'(QD - 2);
	assign in_acc   = in_valid && !in_stall;
	assign out_valid = occ_q != '0;
	assign out_acc  = out_valid && !out_stall;

	always_comb begin
		phase_d  = phase_q;
		low_d    = low_q;
		left_d   = left_q;
		pbi_d    = pbi_q;
		color_d  = color_q;
		wp_mid   = wp_q;
		run_vld  = 1'b0;
		run_res  = '0;
		cnt      = {data_byte, low_q};
		room     = TOTAL - wp_q;
		len      = (CMP_W'(cnt) < CMP_W'(room)) ? POS_W'(cnt) : room;
		lat      = color_q;
		alpha    = srpd_pkg::ALPHA_OPAQUE;
		done_px  = 1'b0;
		left_dec = left_q - 16'd1;

		if (wp_q < TOTAL) begin
			unique case (phase_q)
				srpd_pkg::PH_TRANS_LO: begin
					low_d   = data_byte;
					phase_d = srpd_pkg::PH_TRANS_HI;
				end
				srpd_pkg::PH_TRANS_HI: begin
					if (len != '0) begin
						run_vld = 1'b1;
						run_res.start_index = srpd_pkg::IDX_OUT_W'(wp_q);
						run_res.run_length  = srpd_pkg::LEN_OUT_W'(len);
						wp_mid = wp_q + len;
					end
					phase_d = srpd_pkg::PH_COLOR_LO;
				end
				srpd_pkg::PH_COLOR_LO: begin
					low_d   = data_byte;
					phase_d = srpd_pkg::PH_COLOR_HI;
				end
				srpd_pkg::PH_COLOR_HI: begin
					left_d  = cnt;
					pbi_d   = 2'd0;
					color_d = '0;
					phase_d = (cnt != 16'd0) ? srpd_pkg::PH_PIXEL : srpd_pkg::PH_TRANS_LO;
				end
				srpd_pkg::PH_PIXEL: begin
					// mode sampled per byte: without alpha, byte two or three is blue
					priority if (pbi_q == 2'd0) begin
						lat[23:16] = data_byte;
					end else if (pbi_q == 2'd1) begin
						lat[15:8] = data_byte;
					end else if (pbi_q == 2'd2 || !alpha_mode_q) begin
						lat[7:0] = data_byte;
						done_px  = !alpha_mode_q;
					end else begin
						alpha   = data_byte;
						done_px = 1'b1;
					end
					if (done_px) begin
						run_vld = 1'b1;
						run_res.start_index = srpd_pkg::IDX_OUT_W'(wp_q);
						run_res.run_length  = srpd_pkg::LEN_OUT_W'(1);
						run_res.argb_value  = {alpha, lat};
						wp_mid  = wp_q + POS_W'(1);
						pbi_d   = 2'd0;
						color_d = '0;
						left_d  = left_dec;
						if (left_dec == 16'd0) begin
							phase_d = srpd_pkg::PH_TRANS_LO;
						end
					end else begin
						color_d = lat;
						pbi_d   = pbi_q + 2'd1;
					end
				end
				default: begin
					phase_d = srpd_pkg::PH_TRANS_LO;
				end
			endcase
		end

		// padding run closes the sprite
		pad_vld = last_byte;
		pad_res.start_index = srpd_pkg::IDX_OUT_W'(wp_mid);
		pad_res.run_length  = srpd_pkg::LEN_OUT_W'(TOTAL - wp_mid);
		pad_res.argb_value  = {srpd_pkg::BYTE_ZERO, 24'd0};
		pad_res.sprite_done = 1'b1;
		wp_d = wp_mid;
		if (last_byte) begin
			phase_d = srpd_pkg::PH_TRANS_LO;
			low_d   = '0;
			left_d  = '0;
			pbi_d   = '0;
			color_d = '0;
			wp_d    = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= srpd_pkg::PH_TRANS_LO;
			low_q   <= '0;
			left_q  <= '0;
			pbi_q   <= '0;
			color_q <= '0;
			wp_q    <= '0;
		end else if (in_acc) begin
			phase_q <= phase_d;
			low_q   <= low_d;
			left_q  <= left_d;
			pbi_q   <= pbi_d;
			color_q <= color_d;
			wp_q    <= wp_d;
		end
	end

	// result queue: head at slot 0, shifts on each output beat
	assign base      = occ_q - QC_W'(out_acc);
	assign first_res = run_vld ? run_res : pad_res;
	assign n_push    = in_acc ? (QC_W'(run_vld) + QC_W'(pad_vld)) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= '0;
		end else begin
			occ_q <= base + n_push;
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < QD; i++) begin
			if (n_push != '0 && QC_W'(i) == base) begin
				slot_q[i] <= first_res;
			end else if (n_push == QC_W'(2) && QC_W'(i) == base + QC_W'(1)) begin
				slot_q[i] <= pad_res;
			end else if (out_acc && i < QD - 1) begin
				slot_q[i] <= slot_q[(i < QD - 1) ? i + 1 : i];
			end
		end
	end

	assign start_index = slot_q[0].start_index;
	assign run_length  = slot_q[0].run_length;
	assign argb_value  = slot_q[0].argb_value;
	assign sprite_done = slot_q[0].sprite_done;

	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q <= QC_W'(QD))
		else $error("result queue overflow");

	a_wp_bound: assert property (@(posedge clk) disable iff (!arst_n)
		wp_q <= TOTAL)
		else $error("write position beyond sprite");

	a_last_clears: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && last_byte |=> phase_q == srpd_pkg::PH_TRANS_LO && wp_q == '0 && out_valid)
		else $error("last beat did not restart parse or queue padding run");

endmodule
